[hw/rtl/rtp_pkg.sv]
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared constants of the ramp and triangle rate pacer: default widths,
// register indexes, reset values and fixed field widths.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int TIME_BITS_DEF = 36;
  localparam int RATE_BITS_DEF = 28;

  localparam int KBPS_W = 27;
  localparam int LEN_W  = 32;
  localparam int PKT_W  = 16;
  localparam int TRI_W  = 18;
  localparam int GAP_W  = 40;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_START_RATE = 3'd0;
  localparam logic [IDX_W-1:0] REG_END_RATE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_WIN_START  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIN_LENGTH = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRI_PERIOD = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRI_AMP    = 3'd5;
  localparam logic [IDX_W-1:0] REG_PKT_BYTES  = 3'd6;
  localparam logic [IDX_W-1:0] REG_ENABLE     = 3'd7;

  localparam logic [KBPS_W-1:0] START_RATE_RST = 27'd220000;
  localparam logic [KBPS_W-1:0] END_RATE_RST   = 27'd450000;
  localparam logic [LEN_W-1:0]  WIN_LENGTH_RST = 32'd5000000;
  localparam logic [LEN_W-1:0]  TRI_PERIOD_RST = 32'd200000;
  localparam logic [KBPS_W-1:0] TRI_AMP_RST    = 27'd80000;
  localparam logic [PKT_W-1:0]  PKT_BYTES_RST  = 16'd1200;

  // Packet bits times nanoseconds per millisecond-scaled kbit/s.
  localparam logic [22:0]      NS_PER_BYTE_KBPS = 23'd8000000;
  localparam logic [GAP_W-1:0] IDLE_GAP_NS      = 40'd1000000;

endpackage

[hw/rtl/rtp_query_if.sv]
// ----------------------------------------------------------------------------
// rtp_query_if
// Time stamp channel: valid, ready and the query time.
// ----------------------------------------------------------------------------
interface rtp_query_if #(
  parameter int TIME_BITS = rtp_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_us;

  modport source (output valid, output now_us, input ready);
  modport sink (input valid, input now_us, output ready);
endinterface

[hw/rtl/rtp_result_if.sv]
// ----------------------------------------------------------------------------
// rtp_result_if
// Result channel: valid, ready and the pacing answer for one query.
// ----------------------------------------------------------------------------
interface rtp_result_if #(
  parameter int RATE_BITS = rtp_pkg::RATE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             in_window;
  logic [rtp_pkg::KBPS_W-1:0]       baseline_kbps;
  logic signed [rtp_pkg::TRI_W-1:0] triangle_q16;
  logic [RATE_BITS-1:0]             target_kbps;
  logic [rtp_pkg::GAP_W-1:0]        gap_ns;

  modport source (output valid, output in_window, output baseline_kbps,
                  output triangle_q16, output target_kbps, output gap_ns,
                  input ready);
  modport sink (input valid, input in_window, input baseline_kbps,
                input triangle_q16, input target_kbps, input gap_ns,
                output ready);
endinterface

[hw/rtl/rtp_cfg_if.sv]
// ----------------------------------------------------------------------------
// rtp_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface rtp_cfg_if #(
  parameter int DATA_W = rtp_pkg::TIME_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [rtp_pkg::IDX_W-1:0]  index;
  logic [DATA_W-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/rtp_div.sv]
// ----------------------------------------------------------------------------
// rtp_div
// Pipelined restoring divider, one quotient bit per register stage. The
// numerator must be below den * 2^QUO_W. A side vector travels with the data.
// ----------------------------------------------------------------------------
module rtp_div #(
  parameter int NUM_W  = 40,
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W+NUM_W-1:0] num_ext;
  logic [DEN_W-1:0]       rem_init;

  logic              vld  [QUO_W];
  logic [DEN_W-1:0]  prem [QUO_W];
  logic [QUO_W-1:0]  sh   [QUO_W];
  logic [DEN_W-1:0]  dq   [QUO_W];
  logic [SIDE_W-1:0] sd   [QUO_W];

  assign num_ext  = {{DEN_W{1'b0}}, num};
  assign rem_init = num_ext[QUO_W +: DEN_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic              src_v;
    logic [DEN_W-1:0]  src_rem;
    logic [QUO_W-1:0]  src_sh;
    logic [DEN_W-1:0]  src_den;
    logic [SIDE_W-1:0] src_sd;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_rem = rem_init;
      assign src_sh  = num[QUO_W-1:0];
      assign src_den = den;
      assign src_sd  = side_in;
    end else begin : g_rest
      assign src_v   = vld[k-1];
      assign src_rem = prem[k-1];
      assign src_sh  = sh[k-1];
      assign src_den = dq[k-1];
      assign src_sd  = sd[k-1];
    end

    assign trial = {src_rem, src_sh[QUO_W-1]};
    assign diff  = trial - {1'b0, src_den};
    assign ge    = trial >= {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= src_v;
      end
      if (en) begin
        prem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        sh[k]   <= {src_sh[QUO_W-2:0], ge};
        dq[k]   <= src_den;
        sd[k]   <= src_sd;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo       = sh[QUO_W-1];
  assign rem       = prem[QUO_W-1];
  assign side_out  = sd[QUO_W-1];

endmodule

[hw/rtl/ramp_triangle_rate_pacer.sv]
// ----------------------------------------------------------------------------
// ramp_triangle_rate_pacer
// Answers, for each time stamp, the paced target rate (linear ramp plus a
// triangle modulation) and the gap in nanoseconds until the next packet.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transaction carries
//  -------  ---------  ------------------------------------------------------
//  query    in         now_us, the time stamp in microseconds
//  result   out        in_window, baseline_kbps, triangle_q16, target_kbps,
//                      gap_ns
//  cfg      in         index and data of one register write (ready out of reset)
//
// One query is accepted per cycle while the pipeline advances. It passes 126
// register stages: three front stages, the ramp divider (27 stages), the
// baseline stage, the period remainder (32), the triangle divider (18), three
// modulation stages, the gap numerator stage, the gap divider (40) and the
// output register, one quotient bit per divider stage.
// Reset is synchronous and active high; it empties the pipeline and loads the
// register reset values. No channel accepts a transaction while it is held.
// The whole pipeline advances together; it halts only while a finished result
// sits in the last stage and the sink does not take it, so nothing is lost.
// ----------------------------------------------------------------------------
module ramp_triangle_rate_pacer #(
  parameter int TIME_BITS = rtp_pkg::TIME_BITS_DEF,
  parameter int RATE_BITS = rtp_pkg::RATE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rtp_query_if.sink    query,
  rtp_result_if.source result,
  rtp_cfg_if.sink      cfg
);

  localparam int KW = rtp_pkg::KBPS_W;
  localparam int LW = rtp_pkg::LEN_W;
  localparam int TW = rtp_pkg::TRI_W;
  localparam int GW = rtp_pkg::GAP_W;
  // Width wide enough for both a time stamp and a window length, plus carry.
  localparam int XW = ((TIME_BITS > LW) ? TIME_BITS : LW) + 1;
  localparam int RNUM_W = KW + LW + 1;
  localparam int SUM_W = ((RATE_BITS > KW + 2) ? RATE_BITS : KW + 2) + 1;
  localparam logic [SUM_W-1:0] RMAX =
    {{(SUM_W - RATE_BITS){1'b0}}, {RATE_BITS{1'b1}}};
  localparam int PB_W = rtp_pkg::PKT_W + 23;
  localparam int GNUM_W = ((RATE_BITS > PB_W) ? RATE_BITS : PB_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is idle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [KW-1:0]        start_rate;
  logic [KW-1:0]        end_rate;
  logic [TIME_BITS-1:0] win_start;
  logic [LW-1:0]        win_length;
  logic [LW-1:0]        tri_period;
  logic [KW-1:0]        tri_amp;
  logic [rtp_pkg::PKT_W-1:0] pkt_bytes;
  logic                 enable;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_rate <= rtp_pkg::START_RATE_RST;
      end_rate   <= rtp_pkg::END_RATE_RST;
      win_start  <= '0;
      win_length <= rtp_pkg::WIN_LENGTH_RST;
      tri_period <= rtp_pkg::TRI_PERIOD_RST;
      tri_amp    <= rtp_pkg::TRI_AMP_RST;
      pkt_bytes  <= rtp_pkg::PKT_BYTES_RST;
      enable     <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        rtp_pkg::REG_START_RATE: start_rate <= KW'(cfg.data);
        rtp_pkg::REG_END_RATE:   end_rate   <= KW'(cfg.data);
        rtp_pkg::REG_WIN_START:  win_start  <= TIME_BITS'(cfg.data);
        rtp_pkg::REG_WIN_LENGTH: win_length <= LW'(cfg.data);
        rtp_pkg::REG_TRI_PERIOD: tri_period <= LW'(cfg.data);
        rtp_pkg::REG_TRI_AMP:    tri_amp    <= KW'(cfg.data);
        rtp_pkg::REG_PKT_BYTES:  pkt_bytes  <= rtp_pkg::PKT_W'(cfg.data);
        rtp_pkg::REG_ENABLE:     enable     <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // The rising ramp and the falling ramp share one magnitude divider.
  logic          ramp_up;
  logic [KW-1:0] ramp_span;

  assign ramp_up   = end_rate >= start_rate;
  assign ramp_span = ramp_up ? (end_rate - start_rate) : (start_rate - end_rate);

  // Global advance: every stage moves when the output stage is free or taken.
  logic adv;
  logic out_v;

  assign adv         = !out_v || result.ready;
  assign query.ready = adv && !rst;

  // ---------------------------------------------------------------------------
  // Stage 0: capture the time stamp.
  // ---------------------------------------------------------------------------
  logic                 v0;
  logic [TIME_BITS-1:0] now0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= query.valid;
    end
    if (adv) begin
      now0 <= query.now_us;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: window test and elapsed time. Inside the window the elapsed time
  // never exceeds the window length, so it fits the length width.
  // ---------------------------------------------------------------------------
  logic [XW-1:0] now_x;
  logic [XW-1:0] ws_x;
  logic [XW-1:0] stop_x;
  logic [XW-1:0] elapsed_x;
  logic          v1;
  logic          inwin1;
  logic [LW-1:0] e1;

  assign now_x     = XW'(now0);
  assign ws_x      = XW'(win_start);
  assign stop_x    = ws_x + XW'(win_length);
  assign elapsed_x = now_x - ws_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
    if (adv) begin
      inwin1 <= enable && (now_x >= ws_x) && (now_x <= stop_x);
      e1     <= elapsed_x[LW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: ramp numerator, span times elapsed plus half a window for
  // round-to-nearest.
  // ---------------------------------------------------------------------------
  logic [KW+LW-1:0]  span_prod;
  logic              v2;
  logic              inwin2;
  logic [LW-1:0]     e2;
  logic [RNUM_W-1:0] rnum2;

  assign span_prod = (KW + LW)'(ramp_span) * (KW + LW)'(e1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      inwin2 <= inwin1;
      e2     <= e1;
      rnum2  <= RNUM_W'(span_prod) + RNUM_W'(win_length >> 1);
    end
  end

  // Ramp divider: quotient never exceeds the span, so it fits the rate width.
  logic          rv;
  logic [KW-1:0] rq;
  logic [LW-1:0] rrem_unused;
  logic [LW:0]   rside;

  rtp_div #(
    .NUM_W (RNUM_W),
    .DEN_W (LW),
    .QUO_W (KW),
    .SIDE_W(LW + 1)
  ) u_ramp_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v2),
    .num      (rnum2),
    .den      (win_length),
    .side_in  ({inwin2, e2}),
    .out_valid(rv),
    .quo      (rq),
    .rem      (rrem_unused),
    .side_out (rside)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: baseline. A zero-length window answers the end rate directly.
  // ---------------------------------------------------------------------------
  logic          v3;
  logic          inwin3;
  logic [LW-1:0] e3;
  logic [KW-1:0] base3;
  logic [KW-1:0] base_calc;

  always_comb begin
    if (win_length == '0) begin
      base_calc = end_rate;
    end else if (ramp_up) begin
      base_calc = start_rate + rq;
    end else begin
      base_calc = start_rate - rq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= rv;
    end
    if (adv) begin
      inwin3 <= rside[LW];
      e3     <= rside[LW-1:0];
      base3  <= rside[LW] ? base_calc : '0;
    end
  end

  // Phase within the modulation period: remainder of elapsed time by period.
  logic          mv;
  logic [LW-1:0] mq_unused;
  logic [LW-1:0] phase;
  logic [KW:0]   mside;

  rtp_div #(
    .NUM_W (LW),
    .DEN_W (LW),
    .QUO_W (LW),
    .SIDE_W(KW + 1)
  ) u_phase_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v3),
    .num      (e3),
    .den      (tri_period),
    .side_in  ({inwin3, base3}),
    .out_valid(mv),
    .quo      (mq_unused),
    .rem      (phase),
    .side_out (mside)
  );

  // Phase scaled to 2^18 per period; the phase is below the period, so the
  // quotient fits 18 bits.
  logic             tv;
  logic [TW-1:0]    tx;
  logic [LW-1:0]    trem_unused;
  logic [KW+LW:0]   tside;

  rtp_div #(
    .NUM_W (LW + TW),
    .DEN_W (LW),
    .QUO_W (TW),
    .SIDE_W(KW + LW + 1)
  ) u_tri_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (mv),
    .num      ({phase, {TW{1'b0}}}),
    .den      (tri_period),
    .side_in  ({mside, phase}),
    .out_valid(tv),
    .quo      (tx),
    .rem      (trem_unused),
    .side_out (tside)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: fold the sawtooth into a triangle. First quarter rises from zero,
  // the middle half falls through zero, the last quarter rises back to zero.
  // ---------------------------------------------------------------------------
  logic [LW-1:0]      ph4;
  logic [LW+1:0]      ph_x4;
  logic [LW+1:0]      per_x1;
  logic [LW+1:0]      per_x3;
  logic signed [TW+1:0] xs;
  logic signed [TW+1:0] tri_wide;
  logic signed [TW+1:0] tri_sel;
  logic [TW+1:0]      tri_mag_wide;
  logic               v4;
  logic               inwin4;
  logic [KW-1:0]      base4;
  logic signed [TW-1:0] tri4;
  logic [TW-2:0]      mag4;

  assign ph4    = tside[LW-1:0];
  assign ph_x4  = {ph4, 2'b00};
  assign per_x1 = {2'b00, tri_period};
  assign per_x3 = per_x1 + {1'b0, tri_period, 1'b0};
  assign xs     = $signed({2'b00, tx});

  always_comb begin
    if (ph_x4 < per_x1) begin
      tri_wide = xs;
    end else if (ph_x4 < per_x3) begin
      tri_wide = (TW + 2)'(131072) - xs;
    end else begin
      tri_wide = xs - (TW + 2)'(262144);
    end
    if (!tside[KW+LW] || (tri_period == '0)) begin
      tri_sel = '0;
    end else begin
      tri_sel = tri_wide;
    end
    tri_mag_wide = tri_sel[TW+1] ? $unsigned(-tri_sel) : $unsigned(tri_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= tv;
    end
    if (adv) begin
      inwin4 <= tside[KW+LW];
      base4  <= tside[KW+LW-1:LW];
      tri4   <= tri_sel[TW-1:0];
      mag4   <= tri_mag_wide[TW-2:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: modulation depth, amplitude times |triangle| rounded from Q16.
  // ---------------------------------------------------------------------------
  logic [KW+TW-1:0]     amp_prod;
  logic [KW+TW-1:0]     amp_round;
  logic                 v5;
  logic                 inwin5;
  logic [KW-1:0]        base5;
  logic signed [TW-1:0] tri5;
  logic [KW-1:0]        m5;

  assign amp_prod  = (KW + TW)'(tri_amp) * (KW + TW)'(mag4);
  assign amp_round = amp_prod + (KW + TW)'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      inwin5 <= inwin4;
      base5  <= base4;
      tri5   <= tri4;
      m5     <= amp_round[16 +: KW];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: target rate, clamped at zero and at the rate width. The packet
  // size product for the gap is formed alongside.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]     tsum;
  logic [PB_W-1:0]      pb_prod;
  logic                 v6;
  logic                 inwin6;
  logic [KW-1:0]        base6;
  logic signed [TW-1:0] tri6;
  logic [RATE_BITS-1:0] target6;
  logic [PB_W-1:0]      pb6;

  always_comb begin
    if (base5 == '0) begin
      tsum = '0;
    end else if (tri5 < 0) begin
      tsum = (base5 > m5) ? SUM_W'(base5 - m5) : '0;
    end else begin
      tsum = SUM_W'(base5) + SUM_W'(m5);
    end
  end

  assign pb_prod = PB_W'(pkt_bytes) * PB_W'(rtp_pkg::NS_PER_BYTE_KBPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
    if (adv) begin
      inwin6  <= inwin5;
      base6   <= base5;
      tri6    <= tri5;
      target6 <= (tsum > RMAX) ? RMAX[RATE_BITS-1:0] : tsum[RATE_BITS-1:0];
      pb6     <= pb_prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: gap numerator with half the rate added for rounding.
  // ---------------------------------------------------------------------------
  logic                 v7;
  logic                 inwin7;
  logic [KW-1:0]        base7;
  logic signed [TW-1:0] tri7;
  logic [RATE_BITS-1:0] target7;
  logic [GNUM_W-1:0]    gnum7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
    if (adv) begin
      inwin7  <= inwin6;
      base7   <= base6;
      tri7    <= tri6;
      target7 <= target6;
      gnum7   <= GNUM_W'(pb6) + GNUM_W'(target6 >> 1);
    end
  end

  // Gap divider. A zero rate leaves a meaningless quotient that the output
  // stage replaces with the idle gap.
  localparam int GSIDE_W = 1 + KW + TW + RATE_BITS;

  logic                 gv;
  logic [GW-1:0]        gq;
  logic [RATE_BITS-1:0] grem_unused;
  logic [GSIDE_W-1:0]   gside;

  rtp_div #(
    .NUM_W (GNUM_W),
    .DEN_W (RATE_BITS),
    .QUO_W (GW),
    .SIDE_W(GSIDE_W)
  ) u_gap_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v7),
    .num      (gnum7),
    .den      (target7),
    .side_in  ({inwin7, base7, tri7, target7}),
    .out_valid(gv),
    .quo      (gq),
    .rem      (grem_unused),
    .side_out (gside)
  );

  // ---------------------------------------------------------------------------
  // Output stage: holds the finished transaction until the sink takes it.
  // ---------------------------------------------------------------------------
  logic [RATE_BITS-1:0] gtarget;

  assign gtarget = gside[RATE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= gv;
    end
    if (adv) begin
      result.in_window     <= gside[GSIDE_W-1];
      result.baseline_kbps <= gside[GSIDE_W-2 -: KW];
      result.triangle_q16  <= $signed(gside[RATE_BITS +: TW]);
      result.target_kbps   <= gtarget;
      result.gap_ns        <= (gtarget == '0) ? rtp_pkg::IDLE_GAP_NS : gq;
    end
  end

  assign result.valid = out_v;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ramp and triangle rate pacer. Time stamps go in
// through a queue-fed driver; a monitor compares each pacing answer with a
// local predictor of the ramp, triangle, target and gap arithmetic.
// ----------------------------------------------------------------------------
module tb;

  localparam int TIME_BITS = rtp_pkg::TIME_BITS_DEF;
  localparam int RATE_BITS = rtp_pkg::RATE_BITS_DEF;
  localparam int KBPS_W = rtp_pkg::KBPS_W;
  localparam int LEN_W = rtp_pkg::LEN_W;
  localparam int PKT_W = rtp_pkg::PKT_W;
  localparam int TRI_W = rtp_pkg::TRI_W;
  localparam int GAP_W = rtp_pkg::GAP_W;
  localparam int IDX_W = rtp_pkg::IDX_W;
  // The head of the block quotes 126 register stages from query to result.
  localparam int PIPE_DEPTH = 126;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 9;
  localparam int RANDOM_PER_PHASE = 200;

  // One copy of every pacer register.
  typedef struct {
    logic [KBPS_W-1:0]    start_rate;
    logic [KBPS_W-1:0]    end_rate;
    logic [TIME_BITS-1:0] win_start;
    logic [LEN_W-1:0]     win_length;
    logic [LEN_W-1:0]     tri_period;
    logic [KBPS_W-1:0]    tri_amp;
    logic [PKT_W-1:0]     pkt_bytes;
    logic                 enable;
  } pacer_regs_t;

  // One pacing answer, laid out like the result channel.
  typedef struct {
    logic                    in_window;
    logic [KBPS_W-1:0]       baseline;
    logic signed [TRI_W-1:0] tri_wave;
    logic [RATE_BITS-1:0]    target;
    logic [GAP_W-1:0]        gap;
  } pacing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rtp_query_if  #(.TIME_BITS(TIME_BITS)) query_ch ();
  rtp_result_if #(.RATE_BITS(RATE_BITS)) result_ch ();
  rtp_cfg_if    #(.DATA_W(TIME_BITS))    cfg_ch ();

  ramp_triangle_rate_pacer #(
    .TIME_BITS(TIME_BITS),
    .RATE_BITS(RATE_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .query (query_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pacer_regs_t          pacer_regs;
  logic [TIME_BITS-1:0] pending_stamps[$];
  pacing_t              expected_pacing[$];
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  int unsigned          errors;
  int unsigned          answers_checked;
  int unsigned          answers_in_window;
  int unsigned          cycle_count;

  // Predictor of the pacer. All arithmetic is done in 64 bits, which holds
  // every intermediate product for the register widths used here.
  function automatic pacing_t predict_pacing(input logic [TIME_BITS-1:0] now);
    longint unsigned stop, elapsed, len, ramp_span, quo, base, target;
    longint unsigned period, rem, frac, mag, modul, rate_max, gap;
    longint signed   tri_val;
    pacing_t         p;
    base = 0;
    target = 0;
    tri_val = 0;
    rate_max = (64'd1 << RATE_BITS) - 1;
    len = pacer_regs.win_length;
    period = pacer_regs.tri_period;
    stop = longint'(pacer_regs.win_start) + len;
    p.in_window = pacer_regs.enable && now >= pacer_regs.win_start && now <= stop;
    gap = rtp_pkg::IDLE_GAP_NS;
    if (p.in_window) begin
      elapsed = now - pacer_regs.win_start;
      // Linear ramp, rounded to nearest, ties away from the start rate.
      if (len == 0) begin
        base = pacer_regs.end_rate;
      end else begin
        if (pacer_regs.end_rate >= pacer_regs.start_rate) begin
          ramp_span = pacer_regs.end_rate - pacer_regs.start_rate;
        end else begin
          ramp_span = pacer_regs.start_rate - pacer_regs.end_rate;
        end
        quo = (ramp_span * elapsed + (len >> 1)) / len;
        if (pacer_regs.end_rate >= pacer_regs.start_rate) begin
          base = pacer_regs.start_rate + quo;
        end else begin
          base = pacer_regs.start_rate - quo;
        end
      end
      // Triangle: rises over the first quarter, falls over the middle half,
      // rises again over the last quarter of each period.
      if (period != 0) begin
        rem = elapsed % period;
        frac = (rem << 18) / period;
        if (4 * rem < period) begin
          tri_val = frac;
        end else if (4 * rem < 3 * period) begin
          tri_val = 131072 - longint'(frac);
        end else begin
          tri_val = longint'(frac) - 262144;
        end
      end
      // No modulation is added on a zero baseline.
      if (base != 0) begin
        mag = (tri_val < 0) ? -tri_val : tri_val;
        modul = (longint'(pacer_regs.tri_amp) * mag + 32768) >> 16;
        if (tri_val < 0) begin
          target = (base > modul) ? base - modul : 0;
        end else begin
          target = base + modul;
        end
        if (target > rate_max) begin
          target = rate_max;
        end
      end
      if (target != 0) begin
        gap = (longint'(pacer_regs.pkt_bytes) * 8000000 + (target >> 1)) / target;
      end
    end
    p.baseline = KBPS_W'(base);
    p.tri_wave = TRI_W'(tri_val);
    p.target = RATE_BITS'(target);
    p.gap = GAP_W'(gap);
    return p;
  endfunction

  // Query driver: a new time stamp is offered once the previous transaction
  // has gone through, or when nothing is on offer.
  always @(posedge clk) begin
    if (rst) begin
      query_ch.valid <= 1'b0;
      query_ch.now_us <= '0;
    end else if (!query_ch.valid || query_ch.ready) begin
      if (pending_stamps.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        query_ch.valid <= 1'b1;
        query_ch.now_us <= pending_stamps.pop_front();
      end else begin
        query_ch.valid <= 1'b0;
      end
    end
  end

  // Every accepted query gets its expected answer at the moment it is taken.
  always @(posedge clk) begin
    if (!rst && query_ch.valid && query_ch.ready) begin
      expected_pacing.push_back(predict_pacing(query_ch.now_us));
    end
  end

  // Result sink with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: each result transaction is compared field by field with the
  // oldest prediction.
  always @(posedge clk) begin
    pacing_t exp_p;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_pacing.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual gap_ns %0d",
                 $time, result_ch.gap_ns);
      end else begin
        exp_p = expected_pacing.pop_front();
        answers_checked++;
        if (exp_p.in_window) answers_in_window++;
        if (result_ch.in_window !== exp_p.in_window) begin
          errors++;
          $display("%0t: in_window expected %0d actual %0d", $time,
                   exp_p.in_window, result_ch.in_window);
        end
        if (result_ch.baseline_kbps !== exp_p.baseline) begin
          errors++;
          $display("%0t: baseline_kbps expected %0d actual %0d", $time,
                   exp_p.baseline, result_ch.baseline_kbps);
        end
        if (result_ch.triangle_q16 !== exp_p.tri_wave) begin
          errors++;
          $display("%0t: triangle_q16 expected %0d actual %0d", $time,
                   exp_p.tri_wave, result_ch.triangle_q16);
        end
        if (result_ch.target_kbps !== exp_p.target) begin
          errors++;
          $display("%0t: target_kbps expected %0d actual %0d", $time,
                   exp_p.target, result_ch.target_kbps);
        end
        if (result_ch.gap_ns !== exp_p.gap) begin
          errors++;
          $display("%0t: gap_ns expected %0d actual %0d", $time,
                   exp_p.gap, result_ch.gap_ns);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Writes all eight registers back to back, one transaction per cycle while ready is high.
  // Valid stays high between the writes and is lowered only after the last
  // one is taken.
  task automatic load_registers(input pacer_regs_t regs);
    logic [TIME_BITS-1:0] values[8];
    values[rtp_pkg::REG_START_RATE] = TIME_BITS'(regs.start_rate);
    values[rtp_pkg::REG_END_RATE]   = TIME_BITS'(regs.end_rate);
    values[rtp_pkg::REG_WIN_START]  = regs.win_start;
    values[rtp_pkg::REG_WIN_LENGTH] = TIME_BITS'(regs.win_length);
    values[rtp_pkg::REG_TRI_PERIOD] = TIME_BITS'(regs.tri_period);
    values[rtp_pkg::REG_TRI_AMP]    = TIME_BITS'(regs.tri_amp);
    values[rtp_pkg::REG_PKT_BYTES]  = TIME_BITS'(regs.pkt_bytes);
    values[rtp_pkg::REG_ENABLE]     = TIME_BITS'(regs.enable);
    for (int i = 0; i < 8; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= i[IDX_W-1:0];
      cfg_ch.data <= values[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    pacer_regs = regs;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Register set with the start and end rates sometimes at an extreme, the other fields at random, enable set.
  function automatic pacer_regs_t random_regs();
    pacer_regs_t r;
    r.start_rate = ($urandom_range(3) == 0) ? '1 : KBPS_W'($urandom_range(600000));
    r.end_rate   = ($urandom_range(3) == 0) ? '0 : KBPS_W'($urandom);
    r.win_start  = ($urandom_range(1) == 0) ? TIME_BITS'(rand64()) :
                                              TIME_BITS'($urandom_range(1000));
    r.win_length = ($urandom_range(2) == 0) ? $urandom : $urandom_range(2000000);
    r.tri_period = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300000);
    r.tri_amp    = KBPS_W'($urandom);
    r.pkt_bytes  = PKT_W'($urandom);
    r.enable     = 1'b1;
    return r;
  endfunction

  // Stamps around the window edges, then mostly stamps inside the window and
  // some over the full time range.
  task automatic queue_phase_stamps(input int count);
    longint unsigned stop;
    stop = longint'(pacer_regs.win_start) + pacer_regs.win_length;
    pending_stamps.push_back(pacer_regs.win_start);
    pending_stamps.push_back(pacer_regs.win_start - 1'b1);
    pending_stamps.push_back(TIME_BITS'(stop));
    pending_stamps.push_back(TIME_BITS'(stop + 1));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) begin
        pending_stamps.push_back(TIME_BITS'(pacer_regs.win_start +
                                 rand64() % (longint'(pacer_regs.win_length) + 1)));
      end else begin
        pending_stamps.push_back(TIME_BITS'(rand64()));
      end
    end
  endtask

  initial begin
    pacer_regs_t regs;
    query_ch.valid = 1'b0;
    query_ch.now_us = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = rtp_pkg::REG_START_RATE;
    cfg_ch.data = '0;
    errors = 0;
    answers_checked = 0;
    answers_in_window = 0;
    cycle_count = 0;
    send_idle_pct = 15;
    recv_idle_pct = 80;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // Sender idles a little first, then the receiver, then neither.
      case (ph / 3)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      case (ph)
        0: begin
          // Reset values with the sender running.
          regs = '{rtp_pkg::START_RATE_RST, rtp_pkg::END_RATE_RST, '0,
                   rtp_pkg::WIN_LENGTH_RST, rtp_pkg::TRI_PERIOD_RST,
                   rtp_pkg::TRI_AMP_RST, rtp_pkg::PKT_BYTES_RST, 1'b1};
        end
        1: begin
          // Widest ramp over a one-microsecond window at the top of time,
          // unit period, largest amplitude and zero packet size.
          regs = '{'0, '1, '1, 32'd1, 32'd1, '1, '0, 1'b1};
        end
        2: begin
          // Zero window length, no modulation, falling ramp, largest packet.
          regs = '{'1, 27'd12345, 36'd777, '0, '0, 27'd5000, '1, 1'b1};
        end
        3: begin
          // Zero baseline everywhere in the window.
          regs = '{'0, '0, 36'd100, 32'd400000, 32'd1000, 27'd90000, 16'd64, 1'b1};
        end
        4: begin
          // Stopped sender: every answer is the idle one.
          regs = random_regs();
          regs.enable = 1'b0;
        end
        5: begin
          // Amplitude far above the ramp, so the target clamps at zero
          // on the low side of the wave.
          regs = '{27'd1000, 27'd3000, '0, 32'd100000, 32'd4000, '1, 16'd1500, 1'b1};
        end
        default: regs = random_regs();
      endcase
      load_registers(regs);

      if (ph == 0) begin
        // Quarter points of the triangle, window edges and the extreme stamps.
        pending_stamps.push_back(36'd0);
        pending_stamps.push_back(36'd1);
        pending_stamps.push_back(36'd50000);
        pending_stamps.push_back(36'd100000);
        pending_stamps.push_back(36'd150000);
        pending_stamps.push_back(36'd199999);
        pending_stamps.push_back(36'd200000);
        pending_stamps.push_back(36'd2500000);
        pending_stamps.push_back(36'd4999999);
        pending_stamps.push_back(36'd5000000);
        pending_stamps.push_back(36'd5000001);
        pending_stamps.push_back(36'hFFFFFFFFF);
        pending_stamps.push_back(36'h555555555);
        pending_stamps.push_back(36'hAAAAAAAAA);
      end
      queue_phase_stamps(RANDOM_PER_PHASE);

      // Let the phase drain completely before the next register load.
      while (pending_stamps.size() > 0 || query_ch.valid || expected_pacing.size() > 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (expected_pacing.size() > 0) begin
      errors += expected_pacing.size();
      $display("%0t: %0d expected results never arrived", $time,
               expected_pacing.size());
    end
    $display("Covered %0d register settings and %0d pacing answers, %0d inside the window.",
             PHASES, answers_checked, answers_in_window);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[ramp_triangle_rate_pacer.f]
hw/rtl/rtp_pkg.sv
hw/rtl/rtp_query_if.sv
hw/rtl/rtp_result_if.sv
hw/rtl/rtp_cfg_if.sv
hw/rtl/rtp_div.sv
hw/rtl/ramp_triangle_rate_pacer.sv
verif/tb.sv
